// ===== design/pdvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdvm_pkg
// Shared types and constants for the perspective divide and viewport map.
// ----------------------------------------------------------------------------
package pdvm_pkg;

	localparam int NumLanes = 10;
	localparam int QuoBits  = 32;
	localparam int RemBits  = 64;

	// lane order matches the result fields
	localparam int LaneSx    = 0;
	localparam int LaneSy    = 1;
	localparam int LaneDepth = 2;
	localparam int LaneU     = 3;
	localparam int LaneV     = 4;
	localparam int LaneR     = 5;
	localparam int LaneG     = 6;
	localparam int LaneB     = 7;
	localparam int LaneA     = 8;
	localparam int LaneRecip = 9;

	localparam logic [7:0] RegViewportWidth  = 8'd0;
	localparam logic [7:0] RegViewportHeight = 8'd1;

	localparam logic [12:0] WidthReset  = 13'd640;
	localparam logic [12:0] HeightReset = 13'd480;

	typedef struct packed {
		logic [NumLanes-1:0][RemBits-1:0] rem;
		logic [NumLanes-1:0][QuoBits-1:0] quo;
		logic [NumLanes-1:0]              neg;
		logic [NumLanes-1:0]              ovf;
		logic [31:0]                      den;
		logic                             wz;
	} pdvm_item_t;

	typedef struct packed {
		logic [NumLanes-1:0][31:0] val;
		logic                      wz;
	} pdvm_result_t;

endpackage

// ===== design/perspective_divide_viewport_map.sv =====
// an accepted input transaction passes the prep register, the 32 divide cells and the output register
// throughput: one vertex per cycle; a chain of 32 divide cells, one quotient bit each
// the whole chain advances together and freezes while a result waits on out_stall
// reset: arst_n clears all valid bits; viewport registers return to 640 x 480
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map
// Perspective divide, viewport mapping and attribute scaling by 1/w.
// ----------------------------------------------------------------------------
module perspective_divide_viewport_map import pdvm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] clip_x,
	input  logic [31:0] clip_y,
	input  logic [31:0] clip_z,
	input  logic [31:0] clip_w,
	input  logic [31:0] tex_u,
	input  logic [31:0] tex_v,
	input  logic [31:0] red_in,
	input  logic [31:0] green_in,
	input  logic [31:0] blue_in,
	input  logic [31:0] alpha_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] screen_x,
	output logic [31:0] screen_y,
	output logic [31:0] depth,
	output logic [31:0] tex_u_scaled,
	output logic [31:0] tex_v_scaled,
	output logic [31:0] red_scaled,
	output logic [31:0] green_scaled,
	output logic [31:0] blue_scaled,
	output logic [31:0] alpha_scaled,
	output logic [31:0] recip_w,
	output logic        w_zero
);

	logic [12:0]  width_q, height_q;
	logic         en;
	logic         vld [QuoBits+1];
	pdvm_item_t   itm [QuoBits+1];
	pdvm_result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegViewportWidth:  width_q  <= cfg_data;
				RegViewportHeight: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	pdvm_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_i  (in_valid),
		.clip_x   (clip_x),
		.clip_y   (clip_y),
		.clip_z   (clip_z),
		.clip_w   (clip_w),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.alpha_in (alpha_in),
		.vp_width (width_q),
		.vp_height(height_q),
		.valid_o  (vld[0]),
		.item_o   (itm[0])
	);

	for (genvar k = 0; k < QuoBits; k++) begin : g_cell
		pdvm_div_cell #(.BitPos(QuoBits - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(vld[k]),
			.item_i (itm[k]),
			.valid_o(vld[k+1]),
			.item_o (itm[k+1])
		);
	end

	pdvm_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.valid_i(vld[QuoBits]),
		.item_i (itm[QuoBits]),
		.valid_o(out_valid),
		.res_o  (res)
	);

	assign screen_x     = res.val[LaneSx];
	assign screen_y     = res.val[LaneSy];
	assign depth        = res.val[LaneDepth];
	assign tex_u_scaled = res.val[LaneU];
	assign tex_v_scaled = res.val[LaneV];
	assign red_scaled   = res.val[LaneR];
	assign green_scaled = res.val[LaneG];
	assign blue_scaled  = res.val[LaneB];
	assign alpha_scaled = res.val[LaneA];
	assign recip_w      = res.val[LaneRecip];
	assign w_zero       = res.wz;

	a_zero_w_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> recip_w == 32'd0 && screen_x == 32'd0 && depth == 32'd0)
		else $error("zero w result carries nonzero fields");

	a_recip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !w_zero |-> recip_w != 32'd0)
		else $error("reciprocal of nonzero w came out zero");

	a_chain_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld[QuoBits]) && $stable(vld[0]))
		else $error("divide chain moved while frozen");

endmodule

// ===== design/pdvm_prep.sv =====
// ----------------------------------------------------------------------------
// pdvm_prep
// Forms numerator magnitudes, signs, overflow flags, the zero-w flag and the divisor magnitude, registered.
// ----------------------------------------------------------------------------
module pdvm_prep import pdvm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid_i,
	input  logic [31:0] clip_x,
	input  logic [31:0] clip_y,
	input  logic [31:0] clip_z,
	input  logic [31:0] clip_w,
	input  logic [31:0] tex_u,
	input  logic [31:0] tex_v,
	input  logic [31:0] red_in,
	input  logic [31:0] green_in,
	input  logic [31:0] blue_in,
	input  logic [31:0] alpha_in,
	input  logic [12:0] vp_width,
	input  logic [12:0] vp_height,
	output logic        valid_o,
	output pdvm_item_t  item_o
);

	logic signed [32:0] sum_x, dif_y;
	logic signed [46:0] prod_x, prod_y;
	logic [46:0]        mag_x, mag_y;
	logic [31:0]        den;
	logic [5:0][31:0]   attr;
	logic [31:0]        amag;
	pdvm_item_t         nxt;

	assign attr = {alpha_in, blue_in, green_in, red_in, tex_v, tex_u};

	always_comb begin
		sum_x  = $signed({clip_x[31], clip_x}) + $signed({clip_w[31], clip_w});
		dif_y  = $signed({clip_w[31], clip_w}) - $signed({clip_y[31], clip_y});
		prod_x = sum_x * $signed({1'b0, vp_width});
		prod_y = dif_y * $signed({1'b0, vp_height});
		mag_x  = prod_x[46] ? 47'(-prod_x) : 47'(prod_x);
		mag_y  = prod_y[46] ? 47'(-prod_y) : 47'(prod_y);
		den    = clip_w[31] ? -clip_w : clip_w;
		amag   = '0;

		nxt     = '0;
		nxt.den = den;
		nxt.wz  = (clip_w == 32'd0);

		// (x+w)*width*2^16/(2w) equals (x+w)*width*2^15/w
		nxt.rem[LaneSx] = {2'b0, mag_x, 15'b0};
		nxt.neg[LaneSx] = prod_x[46] ^ clip_w[31];
		nxt.rem[LaneSy] = {2'b0, mag_y, 15'b0};
		nxt.neg[LaneSy] = prod_y[46] ^ clip_w[31];

		amag = clip_z[31] ? -clip_z : clip_z;
		nxt.rem[LaneDepth] = {16'b0, amag, 16'b0};
		nxt.neg[LaneDepth] = clip_z[31] ^ clip_w[31];

		for (int i = 0; i < 6; i++) begin
			amag = attr[i][31] ? -attr[i] : attr[i];
			nxt.rem[LaneU + i] = {16'b0, amag, 16'b0};
			nxt.neg[LaneU + i] = attr[i][31] ^ clip_w[31];
		end

		nxt.rem[LaneRecip] = 64'h0000_0001_0000_0000;
		nxt.neg[LaneRecip] = clip_w[31];

		// quotient would need more than 32 magnitude bits
		for (int i = 0; i < NumLanes; i++)
			nxt.ovf[i] = (nxt.rem[i] >= {den, 32'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_o <= nxt;
		end
	end

endmodule

// ===== design/pdvm_div_cell.sv =====
// ----------------------------------------------------------------------------
// pdvm_div_cell
// One restoring divide step: settles quotient bit BitPos in every lane.
// ----------------------------------------------------------------------------
module pdvm_div_cell import pdvm_pkg::*; #(
	parameter int BitPos = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid_i,
	input  pdvm_item_t item_i,
	output logic       valid_o,
	output pdvm_item_t item_o
);

	logic [RemBits-1:0] trial;
	pdvm_item_t         nxt;

	always_comb begin
		trial = RemBits'(item_i.den) << BitPos;
		nxt   = item_i;
		for (int i = 0; i < NumLanes; i++) begin
			if (item_i.rem[i] >= trial) begin
				nxt.rem[i]         = item_i.rem[i] - trial;
				nxt.quo[i][BitPos] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_o <= nxt;
		end
	end

endmodule

// ===== design/pdvm_post.sv =====
// ----------------------------------------------------------------------------
// pdvm_post
// Applies signs, saturates, and forces zeros for a zero w; output register.
// ----------------------------------------------------------------------------
module pdvm_post import pdvm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         valid_i,
	input  pdvm_item_t   item_i,
	output logic         valid_o,
	output pdvm_result_t res_o
);

	pdvm_result_t nxt;

	always_comb begin
		nxt    = '0;
		nxt.wz = item_i.wz;
		for (int i = 0; i < NumLanes; i++) begin
			if (item_i.wz) begin
				nxt.val[i] = 32'd0;
			end else if (item_i.neg[i]) begin
				if (item_i.ovf[i] || item_i.quo[i] > 32'h8000_0000)
					nxt.val[i] = 32'h8000_0000;
				else
					nxt.val[i] = -item_i.quo[i];
			end else begin
				if (item_i.ovf[i] || item_i.quo[i][31])
					nxt.val[i] = 32'h7FFF_FFFF;
				else
					nxt.val[i] = item_i.quo[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_o <= nxt;
		end
	end

endmodule

// ===== sim/tb_perspective_divide_viewport_map.sv =====
// ----------------------------------------------------------------------------
// tb_perspective_divide_viewport_map
// Drives vertices through the perspective divide, predicts each result from
// exact 64-bit quotients, and checks the results in order with random stalls.
// ----------------------------------------------------------------------------
module tb_perspective_divide_viewport_map import pdvm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 34;
	localparam int IdleLimit = 2000;

	typedef struct packed {
		logic [31:0] x, y, z, w, u, v, r, g, b, a;
	} vertex_t;

	typedef struct packed {
		logic [31:0] sx, sy, dep, u, v, r, g, b, a, rw;
		logic        wz;
	} mapped_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	vertex_t     vin = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	mapped_t     vout;

	logic [12:0] vp_width = WidthReset;
	logic [12:0] vp_height = HeightReset;
	mapped_t     pending_maps[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;
	bit          in_gaps = 1'b1;

	perspective_divide_viewport_map u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.clip_x(vin.x), .clip_y(vin.y), .clip_z(vin.z), .clip_w(vin.w),
		.tex_u(vin.u), .tex_v(vin.v), .red_in(vin.r), .green_in(vin.g),
		.blue_in(vin.b), .alpha_in(vin.a),
		.out_valid(out_valid), .out_stall(out_stall),
		.screen_x(vout.sx), .screen_y(vout.sy), .depth(vout.dep),
		.tex_u_scaled(vout.u), .tex_v_scaled(vout.v), .red_scaled(vout.r),
		.green_scaled(vout.g), .blue_scaled(vout.b), .alpha_scaled(vout.a),
		.recip_w(vout.rw), .w_zero(vout.wz)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] sat_quot(longint num, longint den);
		longint q;
		q = num / den;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic mapped_t map_vertex(vertex_t p);
		mapped_t m;
		longint w;
		w = longint'($signed(p.w));
		m = '0;
		if (w == 0) begin
			m.wz = 1'b1;
			return m;
		end
		m.sx  = sat_quot((longint'($signed(p.x)) + w) * longint'(vp_width) * 65536, 2 * w);
		m.sy  = sat_quot((w - longint'($signed(p.y))) * longint'(vp_height) * 65536, 2 * w);
		m.dep = sat_quot(longint'($signed(p.z)) * 65536, w);
		m.u   = sat_quot(longint'($signed(p.u)) * 65536, w);
		m.v   = sat_quot(longint'($signed(p.v)) * 65536, w);
		m.r   = sat_quot(longint'($signed(p.r)) * 65536, w);
		m.g   = sat_quot(longint'($signed(p.g)) * 65536, w);
		m.b   = sat_quot(longint'($signed(p.b)) * 65536, w);
		m.a   = sat_quot(longint'($signed(p.a)) * 65536, w);
		m.rw  = sat_quot(64'sd4294967296, w);
		return m;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		mapped_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (pending_maps.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, expected none actual %h",
						$time, vout);
				end else begin
					e = pending_maps.pop_front();
					check_field("screen_x", e.sx, vout.sx);
					check_field("screen_y", e.sy, vout.sy);
					check_field("depth", e.dep, vout.dep);
					check_field("tex_u_scaled", e.u, vout.u);
					check_field("tex_v_scaled", e.v, vout.v);
					check_field("red_scaled", e.r, vout.r);
					check_field("green_scaled", e.g, vout.g);
					check_field("blue_scaled", e.b, vout.b);
					check_field("alpha_scaled", e.a, vout.a);
					check_field("recip_w", e.rw, vout.rw);
					check_field("w_zero", {31'd0, e.wz}, {31'd0, vout.wz});
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("** perspective_divide_viewport_map: FAILED **");
				$finish;
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 9);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_vertex(vertex_t p);
		int n;
		if (!calm && in_gaps && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		vin <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_maps.push_back(map_vertex(p));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_maps.size() != 0) @(negedge clk);
		repeat (Latency + 5) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [12:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == RegViewportWidth) vp_width = val;
		else if (idx == RegViewportHeight) vp_height = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0004_0000);
			2: return -$urandom_range(0, 32'h0004_0000);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t p;
		p = {rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
			rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16()};
		// mostly sensible w, sometimes tiny, zero or extreme
		case ($urandom_range(0, 9))
			0: p.w = 32'd0;
			1: p.w = $urandom_range(1, 16) * ($urandom_range(0, 1) ? 1 : -1);
			2: p.w = $urandom();
			default: p.w = $urandom_range(32'h0000_4000, 32'h0010_0000);
		endcase
		return p;
	endfunction

	task automatic test_directed();
		vertex_t p;
		logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0001_0000};
		p = {10{32'h0001_0000}};
		send_vertex(p);
		p.w = 32'd0;              // w zero
		send_vertex(p);
		foreach (edges[i]) begin
			p = {10{edges[(i + 3) % 6]}};
			p.w = edges[i];
			send_vertex(p);
		end
		p = {10{32'h8000_0000}};  // overflow both ways with small w
		p.w = 32'h0000_0001;
		send_vertex(p);
		p.w = 32'hFFFF_FFFF;
		send_vertex(p);
		p = {10{32'h7FFF_FFFF}};
		p.w = 32'h0000_0002;
		send_vertex(p);
		p = {10{32'h0000_8000}};
		p.x = 32'hFFFF_0000;
		p.y = 32'h0001_0000;
		p.w = 32'h0001_0000;
		send_vertex(p);
		drain();
	endtask

	task automatic test_random(int count);
		repeat (count) send_vertex(rand_vertex());
		drain();
	endtask

	task automatic test_viewports();
		write_reg(RegViewportWidth, 13'd0);
		write_reg(RegViewportHeight, 13'd0);
		test_random(100);
		write_reg(RegViewportWidth, 13'h1FFF);
		write_reg(RegViewportHeight, 13'h1FFF);
		test_random(150);
		write_reg(8'd7, 13'd5);   // unknown index
		write_reg(RegViewportWidth, 13'd4096);
		write_reg(RegViewportHeight, 13'd1);
		test_random(150);
		write_reg(RegViewportWidth, 13'd1);
		write_reg(RegViewportHeight, 13'd4096);
		test_random(150);
		write_reg(RegViewportWidth, 13'($urandom_range(1, 4096)));
		write_reg(RegViewportHeight, 13'($urandom_range(1, 4096)));
		test_random(200);
	endtask

	task automatic test_back_to_back();
		in_gaps = 1'b0;
		test_random(300);
		in_gaps = 1'b1;
		calm = 1'b1;
		test_random(300);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(250);
		test_viewports();
		test_back_to_back();
		if (errors == 0)
			$display("** perspective_divide_viewport_map: PASSED **");
		else
			$display("** perspective_divide_viewport_map: FAILED **");
		$finish;
	end

endmodule
